/* design/spm2_pkg.sv */
// shared types and constants of the sprite mode 2 unit
package spm2_pkg;

   typedef enum logic [1:0] {
      OP_WRITE  = 2'd0,
      OP_EVAL   = 2'd1,
      OP_RENDER = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

   localparam logic [1:0] CSR_DISABLE = 2'd0;
   localparam logic [1:0] CSR_LARGE   = 2'd1;
   localparam logic [1:0] CSR_ATTR    = 2'd2;
   localparam logic [1:0] CSR_PATTERN = 2'd3;

   localparam logic [7:0]  END_MARK    = 8'hd8;
   localparam logic [16:0] ATTR_MASK   = 17'h1fe00;
   localparam logic [16:0] COLOR_MASK  = 17'h1fc00;
   localparam logic [7:0]  EARLY_SHIFT = 8'd32;

   typedef struct packed {
      logic [1:0]  operation;
      logic [16:0] mem_address;
      logic [7:0]  mem_data;
      logic [7:0]  line;
      logic [7:0]  column;
      logic [3:0]  color_in;
   } req_type;

   typedef struct packed {
      logic [3:0] color_out;
      logic       collision_flag;
      logic       overflow_flag;
      logic [4:0] overflow_index;
   } rsp_type;

   typedef struct packed {
      logic        sprite_disable;
      logic        large_sprites;
      logic [16:0] attribute_base;
      logic [16:0] pattern_base;
   } cfg_type;

endpackage

/* design/spm2_front.sv */
// input stage: accepts requests and queues them for the engine
module spm2_front
   import spm2_pkg::*;
#(
   parameter int DEPTH = 2
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  req_type push_data,
   output logic    full,
   input  logic    take,
   output logic    ready,
   output req_type head
);
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   req_type        q_ff [DEPTH];
   logic [AW-1:0]  wr_ff, wr_in, rd_ff, rd_in;
   logic [AW:0]    cnt_ff, cnt_in;
   logic           do_push, do_pop;

   assign full    = (cnt_ff == (AW+1)'(DEPTH));
   assign ready   = (cnt_ff != '0);
   assign head    = q_ff[rd_ff];
   assign do_push = push && !full;
   assign do_pop  = take && ready;

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (do_push) begin
         wr_in = (wr_ff == AW'(DEPTH-1)) ? '0 : wr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_in = (rd_ff == AW'(DEPTH-1)) ? '0 : rd_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (!do_push && do_pop) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (do_push) begin
         q_ff[wr_ff] <= push_data;
      end
   end

`ifndef SYNTHESIS
   a_no_overfill: assert property (@(posedge clock) disable iff (reset)
      full |=> !(cnt_ff > (AW+1)'(DEPTH)))
      else $error("front queue overfilled");
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      (!ready && !push) |=> !ready)
      else $error("front queue became nonempty without a push");
   a_count_tracks: assert property (@(posedge clock) disable iff (reset)
      (do_push && !do_pop) |=> (cnt_ff == $past(cnt_ff) + 1'b1))
      else $error("front queue count slip");
`endif
endmodule

/* design/spm2_engine.sv */
// back end: video memory, line evaluation, pixel render and result register
module spm2_engine
   import spm2_pkg::*;
#(
   parameter int MEMORY_BYTES   = 131072,
   parameter int SLOTS_PER_LINE = 8
) (
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  logic    req_ready,
   input  req_type req,
   output logic    req_take,
   output logic    rsp_empty,
   input  logic    rsp_pop,
   output rsp_type rsp_data
);
   localparam int MAW = $clog2(MEMORY_BYTES);
   localparam int SW  = $clog2(SLOTS_PER_LINE);

   typedef enum logic [9:0] {
      ST_IDLE   = 10'b0000000001,
      ST_EADDR  = 10'b0000000010,
      ST_EY     = 10'b0000000100,
      ST_EX     = 10'b0000001000,
      ST_EPAT   = 10'b0000010000,
      ST_ECOL   = 10'b0000100000,
      ST_ESTORE = 10'b0001000000,
      ST_RSLOT  = 10'b0010000000,
      ST_RPAT   = 10'b0100000000,
      ST_DONE   = 10'b1000000000
   } state_type;

   logic [7:0] mem_ff [MEMORY_BYTES];
   logic [7:0] rdata_ff;
   logic [16:0] raddr;
   logic        mem_we;

   logic [7:0] sx_ff [SLOTS_PER_LINE];
   logic [7:0] sy_ff [SLOTS_PER_LINE];
   logic [7:0] sp_ff [SLOTS_PER_LINE];
   logic [3:0] sc_ff [SLOTS_PER_LINE];

   state_type   st_ff, st_in;
   req_type     cur_ff;
   logic [4:0]  ent_ff;
   logic [16:0] aaddr_ff;
   logic [7:0]  ey_ff, ex_ff, ep_ff;
   logic [SW:0] used_ff;
   logic [SW:0] si_ff;
   logic [3:0]  outc_ff;
   logic        coll_ff, ovf_ff;
   logic [4:0]  ovat_ff;
   logic        full_ff;
   rsp_type     out_ff;
   logic [3:0]  dx_ff;

   // evaluation combinational terms
   logic [7:0]  y1;
   logic [8:0]  ylim;
   logic        hit_line;
   logic [7:0]  dline;
   logic [3:0]  lim;

   // render terms
   logic [SW-1:0] sidx;
   logic [7:0]  ox, oy;
   logic [8:0]  xlim;
   logic        hit_col;
   logic [7:0]  dxf, dyf;
   logic [16:0] paddr;
   logic        bit_on;
   logic        last_slot;

   assign lim      = cfg.large_sprites ? 4'd15 : 4'd7;
   assign y1       = ey_ff + 8'd1;
   assign ylim     = {1'b0, y1} + {5'd0, lim};
   assign hit_line = (cur_ff.line >= y1) && ({1'b0, cur_ff.line} <= ylim);
   assign dline    = cur_ff.line - y1;

   assign sidx      = si_ff[SW-1:0];
   assign ox        = sx_ff[sidx];
   assign oy        = sy_ff[sidx];
   assign xlim      = {1'b0, ox} + {5'd0, lim};
   assign hit_col   = (cur_ff.column >= ox) && ({1'b0, cur_ff.column} <= xlim);
   assign dxf       = cur_ff.column - ox;
   assign dyf       = cur_ff.line - oy;
   assign paddr     = cfg.pattern_base + {6'd0, sp_ff[sidx], 3'd0}
                    + {12'd0, dxf[3], 4'd0} + {13'd0, dyf[3:0] & lim};
   assign bit_on    = rdata_ff[3'd7 - dx_ff[2:0]];
   assign last_slot = (si_ff == (SW+1)'(SLOTS_PER_LINE - 1));

   assign req_take  = (st_ff == ST_IDLE) && req_ready && !full_ff;
   assign rsp_empty = !full_ff;
   assign rsp_data  = out_ff;
   assign mem_we    = req_take && (req.operation == OP_WRITE);

   // memory read address by state
   always_comb begin
      raddr = aaddr_ff;
      unique case (st_ff)
         ST_EY:   raddr = aaddr_ff + 17'd1;
         ST_EX:   raddr = aaddr_ff + 17'd2;
         ST_EPAT: raddr = (cfg.attribute_base & COLOR_MASK)
                          + {8'd0, ent_ff, 4'd0} + {9'd0, dline};
         ST_RSLOT: raddr = paddr;
         default: raddr = aaddr_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_ff[req.mem_address[MAW-1:0]] <= req.mem_data;
      end
      rdata_ff <= mem_ff[raddr[MAW-1:0]];
   end

   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         ST_IDLE: begin
            if (req_take) begin
               if (cfg.sprite_disable || req.operation == OP_WRITE
                   || req.operation == OP_NONE) begin
                  st_in = ST_DONE;
               end else if (req.operation == OP_EVAL) begin
                  st_in = ST_EADDR;
               end else begin
                  st_in = ST_RSLOT;
               end
            end
         end
         ST_EADDR:  st_in = ST_EY;
         ST_EY:     st_in = (rdata_ff == END_MARK) ? ST_DONE : ST_EX;
         ST_EX:     st_in = ST_EPAT;
         ST_EPAT:   st_in = !hit_line ? ST_ESTORE
                          : (used_ff == (SW+1)'(SLOTS_PER_LINE)) ? ST_DONE : ST_ECOL;
         ST_ECOL:   st_in = ST_ESTORE;
         ST_ESTORE: st_in = (ent_ff == 5'd31) ? ST_DONE : ST_EADDR;
         ST_RSLOT: begin
            if (oy == END_MARK) begin
               st_in = ST_DONE;
            end else if (hit_col) begin
               st_in = ST_RPAT;
            end else begin
               st_in = last_slot ? ST_DONE : ST_RSLOT;
            end
         end
         ST_RPAT: begin
            if (bit_on && outc_ff != 4'd0) begin
               st_in = ST_DONE;
            end else begin
               st_in = last_slot ? ST_DONE : ST_RSLOT;
            end
         end
         ST_DONE: st_in = ST_IDLE;
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff   <= ST_IDLE;
         full_ff <= 1'b0;
         coll_ff <= 1'b0;
         ovf_ff  <= 1'b0;
         ovat_ff <= '0;
         used_ff <= '0;
         for (int i = 0; i < SLOTS_PER_LINE; i++) begin
            sx_ff[i] <= '0;
            sy_ff[i] <= END_MARK;
            sp_ff[i] <= '0;
            sc_ff[i] <= '0;
         end
      end else begin
         st_ff <= st_in;
         if (full_ff && rsp_pop) begin
            full_ff <= 1'b0;
         end
         unique case (st_ff)
            ST_IDLE: begin
               if (req_take) begin
                  cur_ff   <= req;
                  ent_ff   <= '0;
                  used_ff  <= '0;
                  si_ff    <= '0;
                  outc_ff  <= '0;
                  aaddr_ff <= cfg.attribute_base & ATTR_MASK;
                  if (req.operation == OP_EVAL && !cfg.sprite_disable) begin
                     coll_ff <= 1'b0;
                     ovf_ff  <= 1'b0;
                     ovat_ff <= '0;
                     for (int i = 0; i < SLOTS_PER_LINE; i++) begin
                        sy_ff[i] <= END_MARK;
                     end
                  end
               end
            end
            ST_EY:   ey_ff <= rdata_ff;
            ST_EX:   ex_ff <= rdata_ff;
            ST_EPAT: begin
               ep_ff <= cfg.large_sprites ? (rdata_ff & 8'hfc) : rdata_ff;
               if (hit_line && used_ff == (SW+1)'(SLOTS_PER_LINE)) begin
                  ovf_ff  <= 1'b1;
                  ovat_ff <= ent_ff;
               end
            end
            ST_ECOL: begin
               sx_ff[used_ff[SW-1:0]] <= rdata_ff[7] ? ex_ff - EARLY_SHIFT : ex_ff;
               sy_ff[used_ff[SW-1:0]] <= y1;
               sp_ff[used_ff[SW-1:0]] <= ep_ff;
               sc_ff[used_ff[SW-1:0]] <= rdata_ff[3:0];
               used_ff <= used_ff + 1'b1;
            end
            ST_ESTORE: begin
               ent_ff   <= ent_ff + 5'd1;
               aaddr_ff <= aaddr_ff + 17'd4;
            end
            ST_RSLOT: dx_ff <= dxf[3:0];
            ST_RPAT: begin
               if (bit_on) begin
                  if (outc_ff != 4'd0) begin
                     coll_ff <= 1'b1;
                  end else begin
                     outc_ff <= sc_ff[sidx];
                  end
               end
               si_ff <= si_ff + 1'b1;
            end
            ST_DONE: begin
               full_ff <= 1'b1;
            end
            default: ;
         endcase
         if (st_ff == ST_RSLOT && !hit_col && oy != END_MARK) begin
            si_ff <= si_ff + 1'b1;
         end
      end
   end

   // result register, loaded when the transaction completes
   always_ff @(posedge clock) begin
      if (st_ff == ST_DONE) begin
         out_ff.color_out <= (cur_ff.operation == OP_RENDER && !cfg.sprite_disable
                              && outc_ff != 4'd0) ? outc_ff : cur_ff.color_in;
         out_ff.collision_flag <= coll_ff;
         out_ff.overflow_flag  <= ovf_ff;
         out_ff.overflow_index <= ovat_ff;
      end
   end

`ifndef SYNTHESIS
   a_take_idle: assert property (@(posedge clock) disable iff (reset)
      req_take |-> (st_ff == ST_IDLE && !full_ff))
      else $error("request taken while busy");
   a_done_fills: assert property (@(posedge clock) disable iff (reset)
      (st_ff == ST_DONE) |=> full_ff)
      else $error("result not registered");
   a_slots_bound: assert property (@(posedge clock) disable iff (reset)
      !(used_ff > (SW+1)'(SLOTS_PER_LINE)))
      else $error("slot count over limit");
   a_ovf_index: assert property (@(posedge clock) disable iff (reset)
      !ovf_ff |-> (ovat_ff == '0))
      else $error("overflow index without flag");
`endif
endmodule

/* design/sprite_mode2_line_and_pixel_unit.sv */
// top level of the sprite mode 2 line and pixel unit
// One result per request, in order. A memory write or a disabled/unused
// operation goes straight to completion. A pixel render walks the line slots
// one per cycle plus one memory read per candidate slot; line evaluation
// reads three or four bytes per attribute entry through the single memory
// read port, stepping through address, Y, X and pattern states per entry,
// a colour state when the sprite takes a slot, then a store state.
// The video memory is not cleared.
module sprite_mode2_line_and_pixel_unit
   import spm2_pkg::*;
#(
   parameter int MEMORY_BYTES   = 131072,
   parameter int SLOTS_PER_LINE = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   input  req_type     req_data,
   output logic        req_full,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output rsp_type     rsp_data,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [16:0] csr_data
);
   cfg_type cfg_ff;
   logic    q_ready, q_take;
   req_type q_head;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_DISABLE: cfg_ff.sprite_disable <= csr_data[0];
            CSR_LARGE:   cfg_ff.large_sprites  <= csr_data[0];
            CSR_ATTR:    cfg_ff.attribute_base <= csr_data;
            CSR_PATTERN: cfg_ff.pattern_base   <= csr_data;
            default: ;
         endcase
      end
   end

   spm2_front #(.DEPTH(2)) u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push),
      .push_data (req_data),
      .full      (req_full),
      .take      (q_take),
      .ready     (q_ready),
      .head      (q_head)
   );

   spm2_engine #(
      .MEMORY_BYTES   (MEMORY_BYTES),
      .SLOTS_PER_LINE (SLOTS_PER_LINE)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .req_ready (q_ready),
      .req       (q_head),
      .req_take  (q_take),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );
endmodule
